>>> rtl/ssmp_pkg.sv
// ============================================================================
// ssmp_pkg - shared types and constants of the servo motion profile
// Holds the angle limit, register indexes and controller command struct.
// ============================================================================
`default_nettype none
package ssmp_pkg;

  localparam int AngleW = 15;
  localparam int PulseW = 12;
  localparam int AngleLimit = 11520;
  localparam int UsPerMs = 1000;

  // configuration register indexes
  localparam logic [1:0] RegHome    = 2'd0;
  localparam logic [1:0] RegMin     = 2'd1;
  localparam logic [1:0] RegNeutral = 2'd2;
  localparam logic [1:0] RegMax     = 2'd3;

  // datapath operations, one per controller state
  typedef enum logic [3:0] {
    OpNone  = 4'd0,
    OpLoad  = 4'd1,
    OpDiv   = 4'd2,
    OpU2    = 4'd3,
    OpU3    = 4'd4,
    OpSix   = 4'd5,
    OpPoly  = 4'd6,
    OpBlend = 4'd7,
    OpStep  = 4'd8,
    OpPulA  = 4'd9,
    OpPulB  = 4'd10,
    OpPulQ  = 4'd11,
    OpOut   = 4'd12
  } op_e;

  typedef struct packed {
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic tick_move;  // tick while moving that has not reached the goal
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/ssmp_ctrl.sv
// ============================================================================
// ssmp_ctrl - sequencer of the servo motion profile
// Steps the datapath through divide, shaping, blend and pulse mapping.
// ============================================================================
`default_nettype none
module ssmp_ctrl
  import ssmp_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [12:0] {
    StIdle  = 13'b0000000000001,
    StLoad  = 13'b0000000000010,
    StDiv   = 13'b0000000000100,
    StU2    = 13'b0000000001000,
    StU3    = 13'b0000000010000,
    StSix   = 13'b0000000100000,
    StPoly  = 13'b0000001000000,
    StBlend = 13'b0000010000000,
    StStep  = 13'b0000100000000,
    StPulA  = 13'b0001000000000,
    StPulB  = 13'b0010000000000,
    StPulQ  = 13'b0100000000000,
    StOut   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  // advance the sequence
  always_comb begin
    state_d = state_q;
    cmd_o.op = OpNone;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StLoad;
          cmd_o.op = OpLoad;
        end
      end
      StLoad: begin
        if (sts_i.tick_move) begin
          state_d = StDiv;
        end else begin
          state_d = StPulA;
        end
      end
      StDiv: begin
        cmd_o.op = OpDiv;
        if (sts_i.div_done) state_d = StU2;
      end
      StU2: begin
        cmd_o.op = OpU2;
        state_d = StU3;
      end
      StU3: begin
        cmd_o.op = OpU3;
        state_d = StSix;
      end
      StSix: begin
        cmd_o.op = OpSix;
        state_d = StPoly;
      end
      StPoly: begin
        cmd_o.op = OpPoly;
        state_d = StBlend;
      end
      StBlend: begin
        cmd_o.op = OpBlend;
        state_d = StStep;
      end
      StStep: begin
        cmd_o.op = OpStep;
        state_d = StPulA;
      end
      StPulA: begin
        cmd_o.op = OpPulA;
        state_d = StPulB;
      end
      StPulB: begin
        cmd_o.op = OpPulB;
        state_d = StPulQ;
      end
      StPulQ: begin
        cmd_o.op = OpPulQ;
        state_d = StOut;
      end
      StOut: begin
        cmd_o.op = OpOut;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ssmp_dp.sv
// ============================================================================
// ssmp_dp - datapath of the servo motion profile
// Motion state, serial divider, one shared multiplier and the pulse mapper.
// ============================================================================
`default_nettype none
module ssmp_dp
  import ssmp_pkg::*;
#(
  parameter int TIME_BITS        = 32,
  parameter int DURATION_MS_BITS = 16,
  parameter int FRACTION_BITS    = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  input  wire                         in_func_i,
  input  wire signed [15:0]           in_target_i,
  input  wire [DURATION_MS_BITS-1:0]  in_ms_i,
  input  wire [TIME_BITS-1:0]         in_now_i,
  input  wire                         cfg_valid_i,
  input  wire [1:0]                   cfg_index_i,
  input  wire [31:0]                  cfg_data_i,
  output logic signed [AngleW-1:0]    angle_o,
  output logic [PulseW-1:0]           pulse_o,
  output logic                        moving_o
);

  localparam int F    = FRACTION_BITS;
  localparam int LenW = DURATION_MS_BITS + 10;
  localparam int CmpW = (TIME_BITS > LenW) ? TIME_BITS : LenW;
  localparam int CntW = $clog2(F + 1);
  localparam int ProdW = 2 * (F + 5);
  localparam logic [CntW-1:0] CntLast = CntW'(F - 1);

  logic signed [AngleW-1:0] start_q, goal_q, pos_q;
  logic [PulseW-1:0] min_q, neu_q, max_q;
  logic [TIME_BITS-1:0] t0_q;
  logic [LenW-1:0] len_q;
  logic moving_q;

  // divider, shaping and pulse working registers
  logic tm_q;
  logic [LenW:0] rem_q;
  logic [F-1:0] quo_q;
  logic [CntW-1:0] cnt_q;
  logic [F:0] u2_q, u3_q;
  logic [F+2:0] su2_q;
  logic [F+4:0] p_q;
  logic [F:0] s_q;
  logic signed [F+18:0] prod_q;
  logic [PulseW+14:0] num_q;
  logic [PulseW-1:0] pulse_q;

  function automatic logic signed [AngleW-1:0] clamp(input logic signed [16:0] a);
    if (a < -17'sd11520) return -15'sd11520;
    else if (a > 17'sd11520) return 15'sd11520;
    else return a[AngleW-1:0];
  endfunction

  logic [TIME_BITS-1:0] elapsed;
  logic [LenW-1:0] len_in;
  logic [LenW:0] rem_sh;
  logic tick_move;
  logic [F:0] mul_a;
  logic [F+4:0] mul_b;
  logic [ProdW-1:0] mul_p;
  logic [F+4:0] six_u2, fifteen_u, pos_sum;
  logic signed [16:0] diff;
  logic signed [F+18:0] step_v;
  logic signed [16:0] new_pos;
  logic [14:0] mag;
  logic [PulseW+14:0] dq;

  assign elapsed   = in_now_i - t0_q;
  assign len_in    = LenW'(in_ms_i) * LenW'(UsPerMs);
  assign tick_move = in_func_i && moving_q && (CmpW'(elapsed) < CmpW'(len_q));
  assign sts_o.tick_move = tm_q;
  assign sts_o.div_done  = (cnt_q == CntLast);
  assign rem_sh = {rem_q[LenW-1:0], 1'b0};

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OpU2: begin
        mul_a = (F+1)'(quo_q);
        mul_b = (F+5)'(quo_q);
      end
      OpU3: begin
        mul_a = u2_q;
        mul_b = (F+5)'(quo_q);
      end
      OpPoly: begin
        mul_a = u3_q;
        mul_b = p_q;
      end
      default: ;
    endcase
  end
  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  assign six_u2    = (F+5)'(su2_q);
  assign fifteen_u = (F+5)'(quo_q) * (F+5)'(15);
  assign pos_sum   = six_u2 + (F+5)'(10) * ((F+5)'(1) << F);
  assign diff      = 17'(signed'(goal_q)) - 17'(signed'(start_q));
  assign step_v    = prod_q >>> F;
  assign new_pos   = 17'(signed'(start_q)) + 17'(step_v);
  assign mag       = pos_q[AngleW-1] ? 15'(-pos_q) : 15'(pos_q);
  // divide by 11520 = 2^8 * 45: shift then exact reciprocal for 45
  assign dq        = 27'((64'(num_q >> 8) * 64'd372828) >> 24);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= 12'd500;
      neu_q    <= 12'd1500;
      max_q    <= 12'd2500;
      start_q  <= '0;
      goal_q   <= '0;
      pos_q    <= '0;
      t0_q     <= '0;
      len_q    <= '0;
      moving_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegHome: begin
            if (!moving_q) begin
              start_q <= clamp(17'(signed'(cfg_data_i[AngleW-1:0])));
              goal_q  <= clamp(17'(signed'(cfg_data_i[AngleW-1:0])));
              pos_q   <= clamp(17'(signed'(cfg_data_i[AngleW-1:0])));
            end
          end
          RegMin:     min_q <= cfg_data_i[PulseW-1:0];
          RegNeutral: neu_q <= cfg_data_i[PulseW-1:0];
          RegMax:     max_q <= cfg_data_i[PulseW-1:0];
          default: ;
        endcase
      end
      // apply the item to the motion state
      if (cmd_i.op == OpLoad) begin
        if (!in_func_i) begin
          start_q <= pos_q;
          goal_q  <= clamp(17'(in_target_i));
          t0_q    <= in_now_i;
          len_q   <= len_in;
          if (len_in == '0) begin
            pos_q    <= clamp(17'(in_target_i));
            moving_q <= 1'b0;
          end else begin
            moving_q <= 1'b1;
          end
        end else if (moving_q && !tick_move) begin
          pos_q    <= goal_q;
          moving_q <= 1'b0;
        end
      end
      if (cmd_i.op == OpStep) pos_q <= clamp(new_pos);
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpLoad: begin
        tm_q  <= tick_move;
        rem_q <= (LenW+1)'(elapsed);
        quo_q <= '0;
        cnt_q <= '0;
      end
      OpDiv: begin
        if (rem_sh >= {1'b0, len_q}) begin
          rem_q <= rem_sh - {1'b0, len_q};
          quo_q <= {quo_q[F-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[F-2:0], 1'b0};
        end
        cnt_q <= cnt_q + CntW'(1);
      end
      OpU2: begin
        u2_q  <= (F+1)'(mul_p >> F);
        su2_q <= (F+3)'((mul_p * ProdW'(6)) >> F);
      end
      OpU3: u3_q <= (F+1)'(mul_p >> F);
      OpSix: p_q <= (pos_sum > fifteen_u) ? pos_sum - fifteen_u : '0;
      OpPoly: s_q <= ((mul_p >> F) > ProdW'(1 << F)) ? (F+1)'(1 << F)
                                                      : (F+1)'(mul_p >> F);
      OpBlend: prod_q <= (F+19)'(diff) * (F+19)'(signed'({1'b0, s_q}));
      OpPulA: begin
        if (pos_q[AngleW-1])
          num_q <= 27'(min_q) * 27'(mag) + 27'(neu_q) * 27'(15'd11520 - mag);
        else
          num_q <= 27'(neu_q) * 27'(15'd11520 - mag) + 27'(max_q) * 27'(mag);
      end
      OpPulB: pulse_q <= dq[PulseW-1:0];
      OpPulQ: begin
        if (27'(dq) * 27'(AngleLimit) + 27'(AngleLimit) <= num_q)
          pulse_q <= pulse_q + PulseW'(1);
      end
      default: ;
    endcase
  end

  assign angle_o  = pos_q;
  assign pulse_o  = pulse_q;
  assign moving_o = moving_q;

endmodule
`default_nettype wire

>>> rtl/servo_smootherstep_motion_profile.sv
// ============================================================================
// servo_smootherstep_motion_profile - smootherstep servo trajectory generator
// Takes move and tick items, reports angle, pulse width and moving flag.
// ============================================================================
// Each item yields one result and the block takes one item at a time. A move,
// an idle tick or a tick that reaches the goal goes from the load state
// straight to the pulse mapping; a tick inside a move first runs the
// bit-serial divide of elapsed time by the move length and the shared
// multiplier steps. While the result waits for m_axis_tready the block
// holds it and takes no new item.
`default_nettype none
module servo_smootherstep_motion_profile
  import ssmp_pkg::*;
#(
  parameter int TIME_BITS        = 32,
  parameter int DURATION_MS_BITS = 16,
  parameter int FRACTION_BITS    = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: target_angle, move_ms, now_us (low to high), zero filled
  input  wire [((16+DURATION_MS_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: func
  input  wire         s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata: angle_now, pulse_us (low to high), zero filled
  output logic [31:0] m_axis_tdata,
  // tuser: moving
  output logic        m_axis_tuser,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire [1:0]   cfg_index_i,
  input  wire [31:0]  cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic signed [AngleW-1:0] angle;
  logic [PulseW-1:0] pulse;
  logic in_ready;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = in_ready;

  ssmp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(in_ready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  ssmp_dp #(
    .TIME_BITS(TIME_BITS), .DURATION_MS_BITS(DURATION_MS_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_func_i(s_axis_tuser),
    .in_target_i(s_axis_tdata[15:0]),
    .in_ms_i(s_axis_tdata[16 +: DURATION_MS_BITS]),
    .in_now_i(s_axis_tdata[16+DURATION_MS_BITS +: TIME_BITS]),
    .cfg_valid_i(cfg_valid_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .angle_o(angle), .pulse_o(pulse), .moving_o(m_axis_tuser)
  );

  assign m_axis_tdata = {5'd0, pulse, angle};

endmodule
`default_nettype wire
